/* sv/hfe_pkg.sv */
// hfe_pkg: shared constants, CRC table and queue word type for the HDLC frame encoder
// depends on nothing; used by hfe_front, hfe_fifo, hfe_back and the top level

package hfe_pkg;

    // framing bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // one classified payload word handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        data_esc;
        logic        open;
        logic        last;
        logic [15:0] crc;
        logic        crc_hi_esc;
        logic        crc_lo_esc;
    } cmd_t;

    // byte-wise crc table from the bit-reversed polynomial, indexed msb first
    localparam logic [15:0] CRC_TABLE [0:255] = '{
        16'h0000, 16'h1189, 16'h2312, 16'h329B, 16'h4624, 16'h57AD, 16'h6536, 16'h74BF,
        16'h8C48, 16'h9DC1, 16'hAF5A, 16'hBED3, 16'hCA6C, 16'hDBE5, 16'hE97E, 16'hF8F7,
        16'h1081, 16'h0108, 16'h3393, 16'h221A, 16'h56A5, 16'h472C, 16'h75B7, 16'h643E,
        16'h9CC9, 16'h8D40, 16'hBFDB, 16'hAE52, 16'hDAED, 16'hCB64, 16'hF9FF, 16'hE876,
        16'h2102, 16'h308B, 16'h0210, 16'h1399, 16'h6726, 16'h76AF, 16'h4434, 16'h55BD,
        16'hAD4A, 16'hBCC3, 16'h8E58, 16'h9FD1, 16'hEB6E, 16'hFAE7, 16'hC87C, 16'hD9F5,
        16'h3183, 16'h200A, 16'h1291, 16'h0318, 16'h77A7, 16'h662E, 16'h54B5, 16'h453C,
        16'hBDCB, 16'hAC42, 16'h9ED9, 16'h8F50, 16'hFBEF, 16'hEA66, 16'hD8FD, 16'hC974,
        16'h4204, 16'h538D, 16'h6116, 16'h709F, 16'h0420, 16'h15A9, 16'h2732, 16'h36BB,
        16'hCE4C, 16'hDFC5, 16'hED5E, 16'hFCD7, 16'h8868, 16'h99E1, 16'hAB7A, 16'hBAF3,
        16'h5285, 16'h430C, 16'h7197, 16'h601E, 16'h14A1, 16'h0528, 16'h37B3, 16'h263A,
        16'hDECD, 16'hCF44, 16'hFDDF, 16'hEC56, 16'h98E9, 16'h8960, 16'hBBFB, 16'hAA72,
        16'h6306, 16'h728F, 16'h4014, 16'h519D, 16'h2522, 16'h34AB, 16'h0630, 16'h17B9,
        16'hEF4E, 16'hFEC7, 16'hCC5C, 16'hDDD5, 16'hA96A, 16'hB8E3, 16'h8A78, 16'h9BF1,
        16'h7387, 16'h620E, 16'h5095, 16'h411C, 16'h35A3, 16'h242A, 16'h16B1, 16'h0738,
        16'hFFCF, 16'hEE46, 16'hDCDD, 16'hCD54, 16'hB9EB, 16'hA862, 16'h9AF9, 16'h8B70,
        16'h8408, 16'h9581, 16'hA71A, 16'hB693, 16'hC22C, 16'hD3A5, 16'hE13E, 16'hF0B7,
        16'h0840, 16'h19C9, 16'h2B52, 16'h3ADB, 16'h4E64, 16'h5FED, 16'h6D76, 16'h7CFF,
        16'h9489, 16'h8500, 16'hB79B, 16'hA612, 16'hD2AD, 16'hC324, 16'hF1BF, 16'hE036,
        16'h18C1, 16'h0948, 16'h3BD3, 16'h2A5A, 16'h5EE5, 16'h4F6C, 16'h7DF7, 16'h6C7E,
        16'hA50A, 16'hB483, 16'h8618, 16'h9791, 16'hE32E, 16'hF2A7, 16'hC03C, 16'hD1B5,
        16'h2942, 16'h38CB, 16'h0A50, 16'h1BD9, 16'h6F66, 16'h7EEF, 16'h4C74, 16'h5DFD,
        16'hB58B, 16'hA402, 16'h9699, 16'h8710, 16'hF3AF, 16'hE226, 16'hD0BD, 16'hC134,
        16'h39C3, 16'h284A, 16'h1AD1, 16'h0B58, 16'h7FE7, 16'h6E6E, 16'h5CF5, 16'h4D7C,
        16'hC60C, 16'hD785, 16'hE51E, 16'hF497, 16'h8028, 16'h91A1, 16'hA33A, 16'hB2B3,
        16'h4A44, 16'h5BCD, 16'h6956, 16'h78DF, 16'h0C60, 16'h1DE9, 16'h2F72, 16'h3EFB,
        16'hD68D, 16'hC704, 16'hF59F, 16'hE416, 16'h90A9, 16'h8120, 16'hB3BB, 16'hA232,
        16'h5AC5, 16'h4B4C, 16'h79D7, 16'h685E, 16'h1CE1, 16'h0D68, 16'h3FF3, 16'h2E7A,
        16'hE70E, 16'hF687, 16'hC41C, 16'hD595, 16'hA12A, 16'hB0A3, 16'h8238, 16'h93B1,
        16'h6B46, 16'h7ACF, 16'h4854, 16'h59DD, 16'h2D62, 16'h3CEB, 16'h0E70, 16'h1FF9,
        16'hF78F, 16'hE606, 16'hD49D, 16'hC514, 16'hB1AB, 16'hA022, 16'h92B9, 16'h8330,
        16'h7BC7, 16'h6A4E, 16'h58D5, 16'h495C, 16'h3DE3, 16'h2C6A, 16'h1EF1, 16'h0F78
    };

    // true when a byte must go out as an escape pair
    function automatic logic needs_esc(input logic [7:0] b);
        needs_esc = (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

endpackage

/* sv/hdlc_frame_encoder_crc16.sv */
// hdlc_frame_encoder_crc16: top level, front end, word queue and byte sequencer
// depends on hfe_pkg, hfe_front, hfe_fifo, hfe_back

// HDLC framer: payload words enter on item_valid/item_stall with frame_last on the
// final byte of a frame, and framed bytes leave on byte_valid/byte_stall, one per
// cycle unless stalled. The first byte of a frame is preceded by a 0x7E flag; 0x7E
// and 0x7D are sent as 0x7D plus the byte XOR 0x20. After the last byte the CRC-16
// (init 0xFFFF, no final complement) goes out high byte first, escaped, followed by
// a closing flag marked by frame_done; run_last marks the final byte belonging to
// each input. The front end takes one payload byte per cycle until the
// QUEUE_DEPTH-entry queue fills; each payload byte then costs 1 to 3 output bytes,
// and a closing byte up to 5 more, so the output sequencer sets the sustained
// rate of one byte per unstalled cycle.

module hdlc_frame_encoder_crc16 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] data_byte,
    input  logic       frame_last,
    output logic       byte_valid,
    input  logic       byte_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       frame_done
);

    logic          push;
    hfe_pkg::cmd_t push_cmd;
    logic          queue_full;
    logic          head_valid;
    hfe_pkg::cmd_t head_cmd;
    logic          pop;

    assign item_stall = queue_full;

    hfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .data_byte  (data_byte),
        .frame_last (frame_last),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    hfe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    hfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .byte_stall (byte_stall),
        .byte_valid (byte_valid),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

    // closing flag is always a flag byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && frame_done) |-> (out_byte == hfe_pkg::FLAG_BYTE))
        else $error("closing byte is not a flag");

    // closing flag ends the run of its input word
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && frame_done) |-> run_last)
        else $error("closing flag without run end");

    // an escape byte is never the end of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && out_byte == hfe_pkg::ESC_BYTE) |-> !run_last)
        else $error("run ends on an escape byte");

    // a word leaves the queue only when its final byte is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (byte_valid && run_last))
        else $error("queue popped without a run end");

endmodule

/* sv/hfe_front.sv */
// hfe_front: accepts payload words, runs the frame crc and classifies escapes
// depends on hfe_pkg (cmd_t, CRC_TABLE, needs_esc)

module hfe_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  logic [7:0]    data_byte,
    input  logic          frame_last,
    input  logic          queue_full,
    output logic          push,
    output hfe_pkg::cmd_t push_cmd
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        open_reg;
    logic        open_next;
    logic [15:0] crc_new;
    logic [7:0]  tab_idx;

    // crc update for the incoming byte
    assign tab_idx = data_byte ^ crc_reg[15:8];
    assign crc_new = hfe_pkg::CRC_TABLE[tab_idx] ^ {crc_reg[7:0], 8'h00};

    assign push = item_valid && !queue_full;

    // classified word for the back end
    always_comb
    begin
        push_cmd.data       = data_byte;
        push_cmd.data_esc   = hfe_pkg::needs_esc(data_byte);
        push_cmd.open       = open_reg;
        push_cmd.last       = frame_last;
        push_cmd.crc        = crc_new;
        push_cmd.crc_hi_esc = hfe_pkg::needs_esc(crc_new[15:8]);
        push_cmd.crc_lo_esc = hfe_pkg::needs_esc(crc_new[7:0]);
    end

    // frame state, reloaded after the last byte
    always_comb
    begin
        crc_next  = crc_reg;
        open_next = open_reg;
        if (push)
        begin
            if (frame_last)
            begin
                crc_next  = hfe_pkg::CRC_INIT;
                open_next = 1'b1;
            end
            else
            begin
                crc_next  = crc_new;
                open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= hfe_pkg::CRC_INIT;
            open_reg <= 1'b1;
        end
        else
        begin
            crc_reg  <= crc_next;
            open_reg <= open_next;
        end
    end

endmodule

/* sv/hfe_fifo.sv */
// hfe_fifo: short queue of classified words between front and back
// depends on hfe_pkg (cmd_t); DEPTH from 2 to 32

module hfe_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hfe_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output hfe_pkg::cmd_t head_cmd
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    hfe_pkg::cmd_t    mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* sv/hfe_back.sv */
// hfe_back: sequences the framed output bytes of each queued word
// depends on hfe_pkg (cmd_t, framing constants)

module hfe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  hfe_pkg::cmd_t head_cmd,
    output logic          pop,
    input  logic          byte_stall,
    output logic          byte_valid,
    output logic [7:0]    out_byte,
    output logic          run_last,
    output logic          frame_done
);

    typedef enum logic [3:0] {
        S_START,
        S_OPEN,
        S_DATA,
        S_DATA_X,
        S_CRC_HI,
        S_CRC_HI_X,
        S_CRC_LO,
        S_CRC_LO_X,
        S_CLOSE
    } step_t;

    step_t      step_reg;
    step_t      step_next;
    step_t      cur;
    logic       load;
    logic       fin;
    logic [7:0] emit_byte;
    logic       emit_done;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       done_reg;

    // output register is free when empty or being taken
    assign load = head_valid && (!valid_reg || !byte_stall);
    assign pop  = load && fin;

    // step for the current word
    always_comb
    begin
        if (step_reg == S_START)
        begin
            cur = head_cmd.open ? S_OPEN : S_DATA;
        end
        else
        begin
            cur = step_reg;
        end
    end

    // byte to emit and following step
    always_comb
    begin
        emit_byte = hfe_pkg::FLAG_BYTE;
        emit_done = 1'b0;
        fin       = 1'b0;
        step_next = step_reg;
        case (cur)
            S_OPEN:
            begin
                step_next = S_DATA;
            end
            S_DATA:
            begin
                if (head_cmd.data_esc)
                begin
                    emit_byte = hfe_pkg::ESC_BYTE;
                    step_next = S_DATA_X;
                end
                else
                begin
                    emit_byte = head_cmd.data;
                    step_next = head_cmd.last ? S_CRC_HI : S_START;
                    fin       = !head_cmd.last;
                end
            end
            S_DATA_X:
            begin
                emit_byte = head_cmd.data ^ hfe_pkg::ESC_XOR;
                step_next = head_cmd.last ? S_CRC_HI : S_START;
                fin       = !head_cmd.last;
            end
            S_CRC_HI:
            begin
                if (head_cmd.crc_hi_esc)
                begin
                    emit_byte = hfe_pkg::ESC_BYTE;
                    step_next = S_CRC_HI_X;
                end
                else
                begin
                    emit_byte = head_cmd.crc[15:8];
                    step_next = S_CRC_LO;
                end
            end
            S_CRC_HI_X:
            begin
                emit_byte = head_cmd.crc[15:8] ^ hfe_pkg::ESC_XOR;
                step_next = S_CRC_LO;
            end
            S_CRC_LO:
            begin
                if (head_cmd.crc_lo_esc)
                begin
                    emit_byte = hfe_pkg::ESC_BYTE;
                    step_next = S_CRC_LO_X;
                end
                else
                begin
                    emit_byte = head_cmd.crc[7:0];
                    step_next = S_CLOSE;
                end
            end
            S_CRC_LO_X:
            begin
                emit_byte = head_cmd.crc[7:0] ^ hfe_pkg::ESC_XOR;
                step_next = S_CLOSE;
            end
            S_CLOSE:
            begin
                emit_done = 1'b1;
                fin       = 1'b1;
                step_next = S_START;
            end
            default:
            begin
                step_next = S_START;
            end
        endcase
    end

    // output valid follows load and take
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!byte_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= S_START;
            valid_reg <= 1'b0;
            byte_reg  <= '0;
            last_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                step_reg <= step_next;
                byte_reg <= emit_byte;
                last_reg <= fin;
                done_reg <= emit_done;
            end
        end
    end

    assign byte_valid = valid_reg;
    assign out_byte   = byte_reg;
    assign run_last   = last_reg;
    assign frame_done = done_reg;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for the hdlc_frame_encoder_crc16 framer with crc-16 trailer
// depends on the rtl top level only; it builds its own crc lookup and framing predictor

module testbench;

    // framing bytes and crc constants
    localparam logic [7:0]  FLAG_WORD = 8'h7E;
    localparam logic [7:0]  ESC_WORD  = 8'h7D;
    localparam logic [7:0]  ESC_FLIP  = 8'h20;
    localparam logic [15:0] CRC_SEED  = 16'hFFFF;
    localparam logic [15:0] POLY_REV  = 16'h8408;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    // one framed output word as the link should see it
    typedef struct {
        logic [7:0] value;
        logic       run_end;
        logic       closing;
    } framed_word_t;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    logic [7:0] data_byte;
    logic       frame_last;
    logic       byte_valid;
    logic       byte_stall;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;

    logic [15:0]  crc_lut [0:255];
    logic [15:0]  frame_crc;
    logic         flag_pending;
    framed_word_t expected_words[$];

    bit send_gaps;
    bit recv_stalls;
    int mismatches;
    int words_checked;
    int items_sent;
    int frames_sent;

    hdlc_frame_encoder_crc16 DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .data_byte  (data_byte),
        .frame_last (frame_last),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // lookup entries come from the bit-reversed ccitt polynomial,
    // but the update below indexes and shifts msb first
    task automatic build_crc_lut();
        logic [15:0] r;
        for (int i = 0; i < 256; i++)
        begin
            r = 16'(i);
            for (int k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ POLY_REV) : (r >> 1);
            crc_lut[i] = r;
        end
    endtask

    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] d);
        crc_next = crc_lut[d ^ crc[15:8]] ^ {crc[7:0], 8'h00};
    endfunction

    function automatic bit is_special(input logic [7:0] b);
        is_special = (b == FLAG_WORD) || (b == ESC_WORD);
    endfunction

    // append a byte, split into an escape pair when it collides with framing
    task automatic add_escaped(ref framed_word_t q[$], input logic [7:0] b);
        framed_word_t w;
        w.run_end = 1'b0;
        w.closing = 1'b0;
        if (is_special(b))
        begin
            w.value = ESC_WORD;
            q.push_back(w);
            w.value = b ^ ESC_FLIP;
        end
        else
            w.value = b;
        q.push_back(w);
    endtask

    // framing predictor: words the link should carry for one accepted payload word
    task automatic predict_framing(input logic [7:0] d, input logic l);
        framed_word_t run_words[$];
        framed_word_t w;
        w.run_end = 1'b0;
        w.closing = 1'b0;
        w.value   = FLAG_WORD;
        if (flag_pending)
        begin
            run_words.push_back(w);
            flag_pending = 1'b0;
        end
        frame_crc = crc_next(frame_crc, d);
        add_escaped(run_words, d);
        if (l)
        begin
            add_escaped(run_words, frame_crc[15:8]);
            add_escaped(run_words, frame_crc[7:0]);
            w.closing = 1'b1;
            run_words.push_back(w);
            frame_crc    = CRC_SEED;
            flag_pending = 1'b1;
            frames_sent++;
        end
        run_words[run_words.size() - 1].run_end = 1'b1;
        foreach (run_words[i])
            expected_words.push_back(run_words[i]);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // send one payload word, with an optional idle burst ahead of it
    task automatic send_word(input logic [7:0] d, input logic l);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            item_valid = 1'b0;
            data_byte  = 8'($urandom);
            frame_last = 1'($urandom);
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        item_valid = 1'b1;
        data_byte  = d;
        frame_last = l;
        do
            @(posedge clk);
        while (item_stall);
        items_sent++;
        predict_framing(d, l);
        @(negedge clk);
    endtask

    // hold the input quiet until every predicted word has left the block
    task automatic wait_for_drain();
        item_valid = 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: pick_byte = FLAG_WORD;
            1: pick_byte = ESC_WORD;
            2: pick_byte = $urandom_range(0, 1) ? (FLAG_WORD ^ ESC_FLIP) : (ESC_WORD ^ ESC_FLIP);
            default: pick_byte = 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input int len);
        for (int k = 0; k < len; k++)
            send_word(pick_byte(), k == len - 1);
    endtask

    // three-word frame, last word escaped, whose selected crc bytes also need escaping, if one exists
    task automatic send_crc_escape_frame(input bit want_hi, input bit want_lo);
        logic [15:0] c1;
        logic [15:0] c3;
        logic [7:0]  tail_b;
        logic [7:0]  fa;
        logic [7:0]  fb;
        logic [7:0]  fc;
        bit          found;
        found = 1'b0;
        for (int a = 0; a < 256 && !found; a++)
        begin
            c1 = crc_next(CRC_SEED, 8'(a));
            for (int b = 0; b < 256 && !found; b++)
                for (int ci = 0; ci < 2 && !found; ci++)
                begin
                    tail_b = ci ? ESC_WORD : FLAG_WORD;
                    c3 = crc_next(crc_next(c1, 8'(b)), tail_b);
                    if ((!want_hi || is_special(c3[15:8])) && (!want_lo || is_special(c3[7:0])))
                    begin
                        found = 1'b1;
                        fa = 8'(a);
                        fb = 8'(b);
                        fc = tail_b;
                    end
                end
        end
        if (found)
        begin
            send_word(fa, 1'b0);
            send_word(fb, 1'b0);
            send_word(fc, 1'b1);
        end
    endtask

    // byte extremes, every escape value and its look-alike, escaped crc trailers
    task automatic test_directed();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(FLAG_WORD, 1'b1);
        send_word(ESC_WORD, 1'b1);
        send_word(FLAG_WORD ^ ESC_FLIP, 1'b0);
        send_word(ESC_WORD ^ ESC_FLIP, 1'b0);
        send_word(FLAG_WORD, 1'b0);
        send_word(ESC_WORD, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b1);
        send_crc_escape_frame(1'b1, 1'b0);
        send_crc_escape_frame(1'b0, 1'b1);
        send_crc_escape_frame(1'b1, 1'b1);
    endtask

    // sender stops mid-frame until the link is empty, then finishes the frame and sends a short one
    task automatic test_drain_pause();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        send_word(pick_byte(), 1'b0);
        send_word(pick_byte(), 1'b0);
        send_word(FLAG_WORD, 1'b0);
        wait_for_drain();
        send_word(pick_byte(), 1'b1);
        wait_for_drain();
        send_frame(2);
    endtask

    // random frames, mostly short, with idling switched per frame
    task automatic test_random_frames(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            send_gaps   = $urandom_range(0, 3) != 0;
            recv_stalls = $urandom_range(0, 3) != 0;
            send_frame(len);
            sent += len;
        end
    endtask

    // back-to-back traffic at full rate on both sides
    task automatic test_steady_stream();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        for (int f = 0; f < 5; f++)
            send_frame($urandom_range(1, 7));
    endtask

    // link side stall bursts
    initial
    begin
        byte_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_stalls && $urandom_range(0, 3) == 0)
            begin
                byte_stall = 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            byte_stall = 1'b0;
        end
    end

    // compare every accepted link word with the oldest prediction
    initial
    begin
        framed_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && byte_valid && !byte_stall)
            begin
                words_checked++;
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("word %02h with nothing expected", out_byte));
                else
                begin
                    want = expected_words.pop_front();
                    if (out_byte !== want.value)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_byte, want.value));
                    if (run_last !== want.run_end)
                        report_mismatch($sformatf("run_last %b, expected %b on word %02h",
                                                  run_last, want.run_end, want.value));
                    if (frame_done !== want.closing)
                        report_mismatch($sformatf("frame_done %b, expected %b on word %02h",
                                                  frame_done, want.closing, want.value));
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (byte_valid && !byte_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        data_byte     = 8'h00;
        frame_last    = 1'b0;
        send_gaps     = 1'b0;
        recv_stalls   = 1'b0;
        mismatches    = 0;
        words_checked = 0;
        items_sent    = 0;
        frames_sent   = 0;
        frame_crc     = CRC_SEED;
        flag_pending  = 1'b1;
        build_crc_lut();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_frames(70);
        test_drain_pause();
        test_random_frames(70);
        test_steady_stream();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_words.size()));

        $display("summary: %0d payload words in %0d frames, %0d link words checked",
                 items_sent, frames_sent, words_checked);
        $display("summary: escapes in data and crc trailer, stalls on both sides, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* hdlc_frame_encoder_crc16.f */
sv/hfe_pkg.sv
sv/hfe_front.sv
sv/hfe_fifo.sv
sv/hfe_back.sv
sv/hdlc_frame_encoder_crc16.sv
dv/testbench.sv
